[design/blsr_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded list package
// Shared constants, request and status codes, and the cell control types
// for the bounded list with search and remove.
// ----------------------------------------------------------------------------
package blsr_pkg;

  // Storage geometry.
  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_PULL,
    CELL_MARK,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[design/blsr_cell.sv]
// ----------------------------------------------------------------------------
// Bounded list cell
// Holds one list entry and its occupied flag. Takes the entry of its front
// neighbor on a push, of its back neighbor on a pull, and compares its entry
// against the broadcast value.
// ----------------------------------------------------------------------------
module blsr_cell
  import blsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic                     prev_occ,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic                     next_occ,
  input  logic                     pull_in,
  output logic signed [DATA_W-1:0] data,
  output logic                     occ,
  output logic                     match,
  output logic                     pull_out
);

  // An occupied entry equal to the broadcast value.
  assign match = occ && (data == ctrl.value);

  // Once a cell pulls, every cell behind it pulls as well; a hole or pull_in starts it.
  assign pull_out = pull_in || !occ;

  // Occupied flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_HOLD: ;
        CELL_PUSH: occ <= prev_occ;
        CELL_PULL: begin
          if (pull_out) occ <= next_occ;
        end
        CELL_MARK: begin
          if (match) occ <= 1'b0;
        end
        CELL_CLEAR: occ <= 1'b0;
        default: ;
      endcase
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (ctrl.op == CELL_PUSH) begin
      data <= prev_data;
    end else if (ctrl.op == CELL_PULL && pull_out) begin
      data <= next_data;
    end
  end

endmodule

[design/bounded_list_with_search_remove_unit.sv]
// ----------------------------------------------------------------------------
// Bounded list with search and remove
// Front-first list of up to sixteen signed 32-bit entries kept in a chain of
// cells, with push, pop, read front, contains, remove all equal and clear.
// ----------------------------------------------------------------------------
// Each request beat returns one response beat. Push, pop, read front,
// contains, clear and unused codes complete in the cycle they are accepted;
// the response appears on the next cycle. Remove all equal marks matching
// cells, then closes one gap per cycle by shifting the cells behind the
// first hole toward the front, and responds after no hole is left. The list
// takes one request at a time, and a new request is taken while a response
// waits only if that response is being taken in the same cycle.
module bounded_list_with_search_remove_unit
  import blsr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [REQ_W-1:0]            req_type,
  input  logic signed [DATA_W-1:0]    value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [STAT_W-1:0]           status,
  output logic signed [DATA_W-1:0]    front_value,
  output logic                        found,
  output logic [OUT_CNT_W-1:0]        removed_count,
  output logic [OUT_CNT_W-1:0]        count_after
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_COMPACT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         removed;
  logic [CNT_W-1:0]         match_cnt;

  cell_ctrl_t               ctrl;
  logic                     pull_head;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_occ;
  logic [DEPTH-1:0]         cell_match;
  logic [DEPTH:0]           pull;
  logic                     holes;

  logic                     req_acc;
  logic                     out_free;
  logic                     rsp_load;
  logic [STAT_W-1:0]        status_next;
  logic signed [DATA_W-1:0] front_next;
  logic                     found_next;
  logic [CNT_W-1:0]         removed_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign req_acc   = req_valid && !req_stall;

  // Chain of cells; the front entry lives in cell 0.
  assign pull[0] = pull_head;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_d;
    logic                     prev_o;
    logic signed [DATA_W-1:0] next_d;
    logic                     next_o;

    if (i == 0) begin : g_head
      assign prev_d = value;
      assign prev_o = 1'b1;
    end else begin : g_body
      assign prev_d = cell_data[i-1];
      assign prev_o = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_d = '0;
      assign next_o = 1'b0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
      assign next_o = cell_occ[i+1];
    end

    blsr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_data (prev_d),
      .prev_occ  (prev_o),
      .next_data (next_d),
      .next_occ  (next_o),
      .pull_in   (pull[i]),
      .data      (cell_data[i]),
      .occ       (cell_occ[i]),
      .match     (cell_match[i]),
      .pull_out  (pull[i+1])
    );
  end

  // A hole is an empty cell with an occupied cell right behind it.
  always_comb begin
    holes = 1'b0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      holes = holes | (!cell_occ[i] && cell_occ[i+1]);
    end
  end

  assign match_cnt = CNT_W'($countones(cell_match));

  // Cell command and response fields for the current cycle.
  always_comb begin
    ctrl.op      = CELL_HOLD;
    ctrl.value   = value;
    pull_head    = 1'b0;
    rsp_load     = 1'b0;
    count_next   = count;
    status_next  = STAT_OK;
    front_next   = cell_occ[0] ? cell_data[0] : '0;
    found_next   = 1'b0;
    removed_next = '0;

    if (state == ST_IDLE && req_acc) begin
      rsp_load = 1'b1;
      unique case (req_type)
        REQ_PUSH: begin
          if (count == CNT_W'(DEPTH)) begin
            status_next = STAT_FULL;
          end else begin
            ctrl.op    = CELL_PUSH;
            count_next = count + 1'b1;
            front_next = value;
          end
        end
        REQ_POP: begin
          if (count != '0) begin
            ctrl.op      = CELL_PULL;
            pull_head    = 1'b1;
            count_next   = count - 1'b1;
            removed_next = CNT_W'(1);
            front_next   = (count > CNT_W'(1)) ? cell_data[1] : '0;
          end
        end
        REQ_READ: begin
          if (count == '0) status_next = STAT_EMPTY;
        end
        REQ_CONTAINS: begin
          found_next = |cell_match;
        end
        REQ_REMOVE: begin
          ctrl.op    = CELL_MARK;
          count_next = count - match_cnt;
          rsp_load   = 1'b0;
        end
        REQ_CLEAR: begin
          ctrl.op      = CELL_CLEAR;
          count_next   = '0;
          removed_next = count;
          front_next   = '0;
        end
        default: ;
      endcase
    end else if (state == ST_COMPACT) begin
      if (holes) begin
        ctrl.op = CELL_PULL;
      end else if (out_free) begin
        rsp_load     = 1'b1;
        removed_next = removed;
      end
    end
  end

  // Sequencer, entry count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (rsp_load) begin
        rsp_valid     <= 1'b1;
        status        <= status_next;
        front_value   <= front_next;
        found         <= found_next;
        removed_count <= OUT_CNT_W'(removed_next);
        count_after   <= OUT_CNT_W'(count_next);
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_acc && req_type == REQ_REMOVE) begin
            state   <= ST_COMPACT;
            removed <= match_cnt;
          end
        end
        ST_COMPACT: begin
          if (rsp_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Expected occupancy pattern for a given count.
  logic [DEPTH-1:0] occ_ref;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ_ref[i] = (CNT_W'(i) < count);
    end
  end

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Between requests the occupied cells form a prefix as long as the count.
  a_occ_prefix: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cell_occ == occ_ref)
    else $error("occupied cells disagree with entry count");

  // A rejected push only happens on a full list.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_FULL |-> count_after == OUT_CNT_W'(DEPTH))
    else $error("full status on a list that is not full");

  // Compaction never starts another request before responding.
  a_compact_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMPACT |-> req_stall)
    else $error("request taken during compaction");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Bounded list with search and remove testbench
// Drives request beats into the list with random gaps and response stalls.
// A shadow copy of the list inside the bench computes the expected response
// for every request, and each response beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import blsr_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RAND_ITEMS = 2000;

  // The two request codes that the list ignores.
  localparam logic [REQ_W-1:0] REQ_NOP_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_NOP_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One response beat as the list reports it.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] front;
    logic                     found;
    logic [OUT_CNT_W-1:0]     removed;
    logic [OUT_CNT_W-1:0]     count;
  } list_rsp_t;

  // One row of the directed sequence; typed rows carry their own answer.
  typedef struct packed {
    logic [REQ_W-1:0]         op;
    logic signed [DATA_W-1:0] val;
    int                       reps;
    bit                       typed;
    list_rsp_t                rsp;
  } stim_row_t;

  localparam int N_ROWS = 23;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] front_value;
  logic                     found;
  logic [OUT_CNT_W-1:0]     removed_count;
  logic [OUT_CNT_W-1:0]     count_after;

  // Shadow list, stored oldest first so the front is the top used slot.
  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int                       shadow_len = 0;

  list_rsp_t                rsp_queue [$];
  logic signed [DATA_W-1:0] value_pool [8];
  bit                       quiet = 1'b0;
  int                       err_cnt = 0;
  int                       rsp_checked = 0;
  int                       full_rejects = 0;
  int                       op_seen [8];

  stim_row_t dir_rows [N_ROWS] = '{
    '{REQ_READ,     0,       1,     1'b1, '{STAT_EMPTY, 0,       0, 0,  0}},
    '{REQ_POP,      -7,      1,     1'b1, '{STAT_OK,    0,       0, 0,  0}},
    '{REQ_CONTAINS, 0,       1,     1'b1, '{STAT_OK,    0,       0, 0,  0}},
    '{REQ_REMOVE,   0,       1,     1'b1, '{STAT_OK,    0,       0, 0,  0}},
    '{REQ_CLEAR,    0,       1,     1'b1, '{STAT_OK,    0,       0, 0,  0}},
    '{REQ_PUSH,     VAL_MIN, 1,     1'b1, '{STAT_OK,    VAL_MIN, 0, 0,  1}},
    '{REQ_PUSH,     VAL_MAX, 1,     1'b1, '{STAT_OK,    VAL_MAX, 0, 0,  2}},
    '{REQ_READ,     -1,      1,     1'b1, '{STAT_OK,    VAL_MAX, 0, 0,  2}},
    '{REQ_CONTAINS, VAL_MIN, 1,     1'b1, '{STAT_OK,    VAL_MAX, 1, 0,  2}},
    '{REQ_POP,      1234,    1,     1'b1, '{STAT_OK,    VAL_MIN, 0, 1,  1}},
    '{REQ_NOP_LO,   -1,      1,     1'b1, '{STAT_OK,    VAL_MIN, 0, 0,  1}},
    '{REQ_NOP_HI,   0,       1,     1'b1, '{STAT_OK,    VAL_MIN, 0, 0,  1}},
    '{REQ_CLEAR,    0,       1,     1'b1, '{STAT_OK,    0,       0, 1,  0}},
    '{REQ_PUSH,     5,       DEPTH, 1'b0, '0},
    '{REQ_PUSH,     -1,      1,     1'b1, '{STAT_FULL,  5,       0, 0, 16}},
    '{REQ_CONTAINS, 5,       1,     1'b1, '{STAT_OK,    5,       1, 0, 16}},
    '{REQ_REMOVE,   5,       1,     1'b1, '{STAT_OK,    0,       0, 16, 0}},
    '{REQ_PUSH,     3,       1,     1'b0, '0},
    '{REQ_PUSH,     7,       1,     1'b0, '0},
    '{REQ_PUSH,     3,       1,     1'b0, '0},
    '{REQ_PUSH,     9,       1,     1'b0, '0},
    '{REQ_PUSH,     3,       1,     1'b0, '0},
    '{REQ_REMOVE,   3,       1,     1'b0, '0}
  };

  bounded_list_with_search_remove_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .front_value   (front_value),
    .found         (found),
    .removed_count (removed_count),
    .count_after   (count_after)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one request to the shadow list and returns the response it owes.
  function automatic list_rsp_t apply_list_req(input logic [REQ_W-1:0] op,
                                               input logic signed [DATA_W-1:0] val);
    list_rsp_t r;
    int        kept;
    r = '0;
    case (op)
      REQ_PUSH: begin
        if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_mem[shadow_len] = val;
          shadow_len++;
        end
      end
      REQ_POP: begin
        if (shadow_len > 0) begin
          shadow_len--;
          r.removed = 1;
        end
      end
      REQ_READ: begin
        if (shadow_len == 0) r.status = STAT_EMPTY;
      end
      REQ_CONTAINS: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_mem[i] == val) r.found = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // Matches drop out; the survivors close up in their old order.
        kept = 0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_mem[i] == val) begin
            r.removed++;
          end else begin
            shadow_mem[kept] = shadow_mem[i];
            kept++;
          end
        end
        shadow_len = kept;
      end
      REQ_CLEAR: begin
        r.removed = OUT_CNT_W'(shadow_len);
        shadow_len = 0;
      end
      default: ;
    endcase
    r.front = (shadow_len == 0) ? '0 : shadow_mem[shadow_len - 1];
    r.count = OUT_CNT_W'(shadow_len);
    return r;
  endfunction

  // Picks a request code; the push-heavy mix drives the list toward full.
  function automatic logic [REQ_W-1:0] pick_op(input bit push_heavy);
    int r;
    r = $urandom_range(99);
    if (r < (push_heavy ? 55 : 32)) return REQ_PUSH;
    if (r < 66) return REQ_POP;
    if (r < 73) return REQ_READ;
    if (r < 84) return REQ_CONTAINS;
    if (r < 95) return REQ_REMOVE;
    if (r < 98) return REQ_CLEAR;
    return (r == 98) ? REQ_NOP_LO : REQ_NOP_HI;
  endfunction

  // Mostly values from a small pool so that searches and removals hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 65) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Sends one request beat and queues the response it must produce.
  task automatic send_req(input logic [REQ_W-1:0] op,
                          input logic signed [DATA_W-1:0] val,
                          input bit typed, input list_rsp_t typed_rsp);
    list_rsp_t pred;
    if (!quiet && $urandom_range(99) < 30) begin
      req_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    req_valid = 1'b1;
    req_type  = op;
    value     = val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = apply_list_req(op, val);
    rsp_queue.push_back(typed ? typed_rsp : pred);
    op_seen[op]++;
    if (pred.status == STAT_FULL) full_rejects++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // The response side stalls at random except in the quiet stretch.
  always @(negedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(99) < 30);
  end

  // Every accepted response beat is checked against the oldest expectation.
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_queue.size() == 0) begin
        err_cnt++;
        $display("%0t: response beat with nothing expected, got status %0h count %0d",
                 $time, status, count_after);
      end else begin
        want = rsp_queue.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(status));
        check_field("front_value", want.front, front_value);
        check_field("found", DATA_W'(want.found), DATA_W'(found));
        check_field("removed_count", DATA_W'(want.removed), DATA_W'(removed_count));
        check_field("count_after", DATA_W'(want.count), DATA_W'(count_after));
        rsp_checked++;
      end
    end
  end

  // Hard stop in case the list hangs.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("bounded_list_with_search_remove_unit verification failed");
    $finish;
  end

  // Main stimulus: reset, directed rows, random traffic, then drain.
  initial begin
    bit push_heavy;
    foreach (op_seen[k]) op_seen[k] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows cover empty, full, extreme values and unused codes.
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_req(dir_rows[r].op, dir_rows[r].val, dir_rows[r].typed, dir_rows[r].rsp);
      end
    end

    push_heavy = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) begin
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
        push_heavy = $urandom_range(1);
      end
      quiet = (n >= 600 && n < 900);
      // Hold the request side until the list has answered everything.
      if (n == 1000) begin
        req_valid = 1'b0;
        while (rsp_queue.size() != 0) @(negedge clk);
      end
      send_req(pick_op(push_heavy), pick_value(), 1'b0, '0);
    end
    req_valid = 1'b0;
    quiet = 1'b0;

    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    $display("Covered %0d push, %0d pop, %0d read, %0d contains, %0d remove, %0d clear,",
             op_seen[REQ_PUSH], op_seen[REQ_POP], op_seen[REQ_READ],
             op_seen[REQ_CONTAINS], op_seen[REQ_REMOVE], op_seen[REQ_CLEAR]);
    $display("%0d unused-code requests, %0d full rejects, %0d responses checked.",
             op_seen[REQ_NOP_LO] + op_seen[REQ_NOP_HI], full_rejects, rsp_checked);
    if (err_cnt == 0 && rsp_queue.size() == 0) begin
      $display("bounded_list_with_search_remove_unit verification clean");
    end else begin
      $display("bounded_list_with_search_remove_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/blsr_pkg.sv
design/blsr_cell.sv
design/bounded_list_with_search_remove_unit.sv
tb/tb_top.sv
